/* rtl/core/mrfc_pkg.sv */
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the Modbus
// RTU request frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam int DEF_MAX_FRAME = 256;
    localparam int CNT_W         = 9;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_WR_COIL   = 8'h05;
    localparam logic [7:0] FUNC_WR_REG    = 8'h06;
    localparam logic [7:0] FUNC_WR_COILS  = 8'h0F;
    localparam logic [7:0] FUNC_WR_REGS   = 8'h10;
    localparam logic [7:0] FUNC_BLOCK_XFR = 8'h41;

    localparam int MIN_LEN     = 4;
    localparam int WR_MIN_LEN  = 7;
    localparam int FIXED_LEN   = 8;
    localparam int WR_HDR_LEN  = 9;
    localparam int BLK_HDR_LEN = 6;

    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_CRC_BAD   = 3'd2;
    localparam logic [2:0] VERDICT_LEN_BAD   = 3'd3;
    localparam logic [2:0] VERDICT_NOT_ADDR  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_req;

    typedef struct packed {
        logic [2:0]       verdict;
        logic [7:0]       function_code;
        logic             is_broadcast;
        logic [CNT_W-1:0] frame_length;
    } t_rsp;

    typedef struct packed {
        logic [15:0]      crc;
        logic [CNT_W-1:0] length;
        logic [7:0]       address;
        logic [7:0]       function_code;
        logic [7:0]       third;
        logic [7:0]       sixth;
    } t_summary;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/mrfc_front.sv */
// ----------------------------------------------------------------------------
// mrfc_front
// Accepts request bytes, runs the CRC and byte count, captures header bytes
// and emits one frame summary on the last byte.
// ----------------------------------------------------------------------------
module mrfc_front #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mrfc_pkg::t_req    i_req,
    output logic              o_full,
    output logic              o_sum_push,
    output mrfc_pkg::t_summary o_sum,
    input  logic              i_q_full
);
    import mrfc_pkg::*;

    localparam logic [CNT_W-1:0] SAT_LEN = CNT_W'(MAX_FRAME + 1);

    logic [15:0]      r_crc, n_crc;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_third, n_third;
    logic [7:0]       r_sixth, n_sixth;
    logic             w_take;

    assign o_full = i_q_full;
    assign w_take = i_push && !i_q_full;

    always_comb begin
        n_addr  = r_addr;
        n_func  = r_func;
        n_third = r_third;
        n_sixth = r_sixth;
        unique case (r_count)
            CNT_W'(0): n_addr  = i_req.data_byte;
            CNT_W'(1): n_func  = i_req.data_byte;
            CNT_W'(3): n_third = i_req.data_byte;
            CNT_W'(6): n_sixth = i_req.data_byte;
            default: ;
        endcase
        n_crc   = crc_byte(r_crc, i_req.data_byte);
        n_count = (r_count < SAT_LEN) ? r_count + CNT_W'(1) : r_count;
    end

    assign o_sum_push          = w_take && i_req.frame_end;
    assign o_sum.crc           = n_crc;
    assign o_sum.length        = n_count;
    assign o_sum.address       = n_addr;
    assign o_sum.function_code = n_func;
    assign o_sum.third         = n_third;
    assign o_sum.sixth         = n_sixth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_req.frame_end)) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_third <= '0;
            r_sixth <= '0;
        end else if (w_take) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_third <= n_third;
            r_sixth <= n_sixth;
        end
    end

endmodule

/* rtl/core/mrfc_queue.sv */
// ----------------------------------------------------------------------------
// mrfc_queue
// Short queue of frame summaries between the front and the back.
// ----------------------------------------------------------------------------
module mrfc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mrfc_pkg::t_summary i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output mrfc_pkg::t_summary o_data
);
    import mrfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_summary            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_QW-1:0]   r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

/* rtl/core/mrfc_back.sv */
// ----------------------------------------------------------------------------
// mrfc_back
// Judges one frame summary per cycle while the output register is free or
// being taken, and holds the verdict there until it is taken.
// ----------------------------------------------------------------------------
module mrfc_back #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_own_address,
    input  logic               i_q_empty,
    input  mrfc_pkg::t_summary i_sum,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output mrfc_pkg::t_rsp     o_rsp
);
    import mrfc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] WR_LIMIT  = CNT_W'(MAX_FRAME - WR_HDR_LEN);
    localparam logic [CNT_W-1:0] BLK_LIMIT = CNT_W'(MAX_FRAME - BLK_HDR_LEN);

    logic             r_valid;
    t_rsp             r_rsp;
    logic [2:0]       w_verdict;
    logic [CNT_W-1:0] w_len;
    logic [CNT_W-1:0] w_sixth;
    logic [CNT_W-1:0] w_third;
    logic             w_bcast;
    logic             w_write_fn;
    logic             w_multi_wr;

    assign w_len      = i_sum.length;
    assign w_sixth    = {{(CNT_W-8){1'b0}}, i_sum.sixth};
    assign w_third    = {{(CNT_W-8){1'b0}}, i_sum.third};
    assign w_bcast    = (i_sum.address == 8'h00);
    assign w_multi_wr = (i_sum.function_code == FUNC_WR_COILS) ||
                        (i_sum.function_code == FUNC_WR_REGS);
    assign w_write_fn = w_multi_wr || (i_sum.function_code == FUNC_WR_COIL) ||
                        (i_sum.function_code == FUNC_WR_REG);

    always_comb begin
        priority if (w_len < CNT_W'(MIN_LEN)) begin
            w_verdict = VERDICT_SHORT;
        end else if (i_sum.crc != 16'h0000) begin
            w_verdict = VERDICT_CRC_BAD;
        end else if (w_len > MAX_LEN) begin
            w_verdict = VERDICT_LEN_BAD;
        end else if (w_multi_wr && ((w_len < CNT_W'(WR_MIN_LEN)) || (w_sixth > WR_LIMIT) ||
                                    (w_len != w_sixth + CNT_W'(WR_HDR_LEN)))) begin
            w_verdict = VERDICT_LEN_BAD;
        end else if ((i_sum.function_code == FUNC_BLOCK_XFR) &&
                     ((w_third > BLK_LIMIT) || (w_len != w_third + CNT_W'(BLK_HDR_LEN)))) begin
            w_verdict = VERDICT_LEN_BAD;
        end else if (!w_multi_wr && (i_sum.function_code != FUNC_BLOCK_XFR) &&
                     (w_len != CNT_W'(FIXED_LEN))) begin
            w_verdict = VERDICT_LEN_BAD;
        end else if (!w_bcast && (i_sum.address != i_own_address)) begin
            w_verdict = VERDICT_NOT_ADDR;
        end else if (w_bcast && !w_write_fn) begin
            w_verdict = VERDICT_NOT_ADDR;
        end else begin
            w_verdict = VERDICT_OK;
        end
    end

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rsp.verdict       <= w_verdict;
            r_rsp.function_code <= i_sum.function_code;
            r_rsp.is_broadcast  <= w_bcast;
            r_rsp.frame_length  <= w_len;
        end
    end

endmodule

/* rtl/core/modbus_rtu_request_frame_check_core.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_request_frame_check_core
// Modbus RTU request frame checker: CRC-16/MODBUS, length and address checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one request byte per accepted push (i_push high, o_full
//   low), with frame_end set on the last byte of the frame. Bytes are taken
//   back to back, one per cycle while o_full is low.
//   Result channel: one verdict per frame, shown while o_empty is low and
//   taken with i_pop. After the last byte is accepted, its summary goes into
//   the summary queue and then into the output register once that is free.
//   Throughput: one byte per cycle while o_full is low; one verdict per cycle
//   at most, while results are taken; CRC update and judge are combinational.
//   Configuration: own_address is written via i_cfg_valid/i_cfg_data, always
//   ready; the user must do so only while no frame is in flight; not enforced.
//   Reset: frame state clears, the summary queue and output empty, the
//   station address returns to 1.
//   Stall: a held result lets the two-entry summary queue fill; once it is
//   full o_full rises and every byte, mid-frame ones too, waits.
// ----------------------------------------------------------------------------
module modbus_rtu_request_frame_check_core #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrfc_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mrfc_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    input  logic [7:0]     i_cfg_data,
    output logic           o_cfg_ready
);
    import mrfc_pkg::*;

    logic [7:0] r_own_address;
    logic       w_sum_push;
    t_summary   w_sum_in;
    t_summary   w_sum_out;
    logic       w_q_full;
    logic       w_q_empty;
    logic       w_q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 8'd1;
        end else if (i_cfg_valid) begin
            r_own_address <= i_cfg_data;
        end
    end

    mrfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_req      (i_req),
        .o_full     (o_full),
        .o_sum_push (w_sum_push),
        .o_sum      (w_sum_in),
        .i_q_full   (w_q_full)
    );

    mrfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_sum_push),
        .i_data  (w_sum_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_sum_out)
    );

    mrfc_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_address (r_own_address),
        .i_q_empty     (w_q_empty),
        .i_sum         (w_sum_out),
        .o_q_pop       (w_q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_rsp         (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("summary queue both full and empty");

    a_frame_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_req.frame_end) |=> !w_q_empty)
        else $error("frame end accepted but no summary queued");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_rsp.verdict <= VERDICT_NOT_ADDR))
        else $error("verdict code out of range");

    a_pop_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (!w_q_empty && (o_empty || i_pop)))
        else $error("summary taken while output register busy");
`endif

endmodule
